/* rtl/core/mrwc_pkg.sv */
package mrwc_pkg;

    // Default grid capacity.
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    // Register and field widths fixed by the interface.
    localparam int GRID_W = 6;
    localparam int DIM_W  = GRID_W + 1;
    localparam int POS_W  = 5;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [GRID_W-1:0] ROWS_RST = 6'd15;
    localparam logic [GRID_W-1:0] COLS_RST = 6'd20;

    // Register indexes, selected by the upper address bit.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Stream word widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Result queue depth.
    localparam int OUTQ_DEPTH = 4;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        DIR_ROW_INC = 2'd0,
        DIR_COL_INC = 2'd1,
        DIR_ROW_DEC = 2'd2,
        DIR_COL_DEC = 2'd3
    } t_dir;

    // Control that travels from the walk stage to the marking stage.
    typedef struct packed {
        logic vld;
        logic is_start;
        logic acc;
    } t_stage_ctl;

    // One result word; the first member sits in the highest bits.
    typedef struct packed {
        logic             done_res;
        logic [POS_W-1:0] to_col;
        logic [POS_W-1:0] to_row;
        logic [POS_W-1:0] from_col;
        logic [POS_W-1:0] from_row;
        logic             carve;
        logic             accepted;
    } t_result;

    localparam int RES_PAD = M_TDATA_W - $bits(t_result);

endpackage

/* rtl/core/mrwc_ram.sv */
module mrwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; a read at the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mrwc_walk.sv */
module mrwc_walk #(
    parameter int MAX_ROWS = mrwc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mrwc_pkg::MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_vld,
    input  mrwc_pkg::t_opcode             i_opcode,
    input  logic [mrwc_pkg::POS_W-1:0]    i_seed_row,
    input  logic [mrwc_pkg::POS_W-1:0]    i_seed_col,
    input  mrwc_pkg::t_dir                i_dir,
    input  logic [$clog2(MAX_ROWS+1)-1:0] i_rows_eff,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_cols_eff,
    input  logic                          i_done_now,
    output logic                          o_active,
    output mrwc_pkg::t_stage_ctl          o_ctl,
    output logic [$clog2(MAX_ROWS)-1:0]   o_from_row,
    output logic [$clog2(MAX_COLS)-1:0]   o_from_col,
    output logic [$clog2(MAX_ROWS)-1:0]   o_to_row,
    output logic [$clog2(MAX_COLS)-1:0]   o_to_col
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int DW = mrwc_pkg::DIM_W;

    // Input register.
    logic                       r_vld;
    mrwc_pkg::t_opcode          r_op;
    logic [mrwc_pkg::POS_W-1:0] r_seed_row;
    logic [mrwc_pkg::POS_W-1:0] r_seed_col;
    mrwc_pkg::t_dir             r_dir;

    // Walk state.
    logic [RW-1:0] r_walk_row;
    logic [CW-1:0] r_walk_col;
    logic          r_active;

    logic [RW:0]   w_tr;
    logic [CW:0]   w_tc;
    logic          w_step_ok;
    logic          w_seed_ok;
    logic          w_in_grid;
    logic          w_is_start;
    logic          w_acc;
    logic [RW-1:0] w_tgt_row;
    logic [CW-1:0] w_tgt_col;
    logic [RW-1:0] n_walk_row;
    logic [CW-1:0] n_walk_col;
    logic          n_active;

    // Neighbor cell in the requested direction; stepping below zero is refused.
    always_comb begin
        w_step_ok = 1'b1;
        w_tr      = {1'b0, r_walk_row};
        w_tc      = {1'b0, r_walk_col};
        unique case (r_dir)
            mrwc_pkg::DIR_ROW_INC: begin
                w_tr = {1'b0, r_walk_row} + (RW+1)'(1);
            end
            mrwc_pkg::DIR_COL_INC: begin
                w_tc = {1'b0, r_walk_col} + (CW+1)'(1);
            end
            mrwc_pkg::DIR_ROW_DEC: begin
                w_step_ok = (r_walk_row != '0);
                w_tr      = {1'b0, r_walk_row} - (RW+1)'(1);
            end
            mrwc_pkg::DIR_COL_DEC: begin
                w_step_ok = (r_walk_col != '0);
                w_tc      = {1'b0, r_walk_col} - (CW+1)'(1);
            end
        endcase
    end

    // Bounds checks against the grid currently in use.
    assign w_seed_ok = (DW'(r_seed_row) < DW'(i_rows_eff)) &&
                       (DW'(r_seed_col) < DW'(i_cols_eff));
    assign w_in_grid = (DW'(w_tr) < DW'(i_rows_eff)) && (DW'(w_tc) < DW'(i_cols_eff));

    assign w_is_start = (r_op == mrwc_pkg::OP_START);
    assign w_acc      = w_is_start ? w_seed_ok
                                   : (r_active && !i_done_now && w_step_ok && w_in_grid);

    assign w_tgt_row  = w_is_start ? RW'(r_seed_row) : w_tr[RW-1:0];
    assign w_tgt_col  = w_is_start ? CW'(r_seed_col) : w_tc[CW-1:0];
    assign n_walk_row = w_acc ? w_tgt_row : r_walk_row;
    assign n_walk_col = w_acc ? w_tgt_col : r_walk_col;
    assign n_active   = r_active || (w_acc && w_is_start);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_walk_row <= '0;
            r_walk_col <= '0;
            r_active   <= 1'b0;
        end else begin
            r_vld <= i_in_vld;
            if (r_vld) begin
                r_walk_row <= n_walk_row;
                r_walk_col <= n_walk_col;
                r_active   <= n_active;
            end
        end
    end

    // Input word payload.
    always_ff @(posedge i_clk) begin
        if (i_in_vld) begin
            r_op       <= i_opcode;
            r_seed_row <= i_seed_row;
            r_seed_col <= i_seed_col;
            r_dir      <= i_dir;
        end
    end

    assign o_active     = r_active;
    assign o_ctl.vld      = r_vld;
    assign o_ctl.is_start = w_is_start;
    assign o_ctl.acc      = w_acc;
    assign o_from_row   = r_walk_row;
    assign o_from_col   = r_walk_col;
    assign o_to_row     = n_walk_row;
    assign o_to_col     = n_walk_col;

endmodule

/* rtl/core/mrwc_mark.sv */
module mrwc_mark #(
    parameter int MAX_ROWS = mrwc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mrwc_pkg::MAX_COLS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mrwc_pkg::t_stage_ctl                     i_ctl,
    input  logic [$clog2(MAX_ROWS)-1:0]              i_from_row,
    input  logic [$clog2(MAX_COLS)-1:0]              i_from_col,
    input  logic [$clog2(MAX_ROWS)-1:0]              i_to_row,
    input  logic [$clog2(MAX_COLS)-1:0]              i_to_col,
    input  logic                                     i_active,
    input  logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0]   i_total,
    output logic                                     o_done_now,
    output logic                                     o_res_vld,
    output mrwc_pkg::t_result                        o_res
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_ROWS*MAX_COLS+1);

    // Stage register.
    mrwc_pkg::t_stage_ctl r_ctl;
    logic [RW-1:0]        r_from_row;
    logic [CW-1:0]        r_from_col;
    logic [RW-1:0]        r_to_row;
    logic [CW-1:0]        r_to_col;

    // Visited store: one word per row, a flag per row tells whether it was written
    // since the last start.
    logic [MAX_ROWS-1:0]  r_row_vld;
    logic [CNT_W-1:0]     r_count;

    // Last word written, for a read that was taken at the same edge.
    logic                 r_fwd_vld;
    logic [RW-1:0]        r_fwd_row;
    logic [MAX_COLS-1:0]  r_fwd_data;

    logic [MAX_COLS-1:0]  w_rd_data;
    logic [MAX_COLS-1:0]  w_row_cur;
    logic [MAX_COLS-1:0]  w_mask;
    logic                 w_start_acc;
    logic                 w_carve;
    logic                 w_we;
    logic [MAX_COLS-1:0]  w_wdata;
    logic [CNT_W-1:0]     n_count;
    logic [MAX_ROWS-1:0]  n_row_vld;

    mrwc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_to_row),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.vld),
        .i_raddr (i_to_row),
        .o_rdata (w_rd_data)
    );

    // Current contents of the target row.
    always_comb begin
        if (r_fwd_vld && (r_fwd_row == r_to_row)) begin
            w_row_cur = r_fwd_data;
        end else if (r_row_vld[r_to_row]) begin
            w_row_cur = w_rd_data;
        end else begin
            w_row_cur = '0;
        end
    end

    assign w_mask      = {{(MAX_COLS-1){1'b0}}, 1'b1} << r_to_col;
    assign w_start_acc = r_ctl.vld && r_ctl.acc && r_ctl.is_start;
    assign w_carve     = r_ctl.vld && r_ctl.acc && !r_ctl.is_start && !w_row_cur[r_to_col];
    assign w_we        = w_start_acc || w_carve;
    assign w_wdata     = w_start_acc ? w_mask : (w_row_cur | w_mask);

    // Visited count and row flags after this word.
    always_comb begin
        n_count   = r_count;
        n_row_vld = r_row_vld;
        if (w_start_acc) begin
            n_count   = CNT_W'(1);
            n_row_vld = '0;
            n_row_vld[r_to_row] = 1'b1;
        end else if (w_carve) begin
            n_count = r_count + CNT_W'(1);
            n_row_vld[r_to_row] = 1'b1;
        end
    end

    assign o_done_now = i_active && (n_count >= i_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= '0;
            r_row_vld <= '0;
            r_count   <= '0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_ctl     <= i_ctl;
            r_row_vld <= n_row_vld;
            r_count   <= n_count;
            r_fwd_vld <= w_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from_row <= i_from_row;
        r_from_col <= i_from_col;
        r_to_row   <= i_to_row;
        r_to_col   <= i_to_col;
        if (w_we) begin
            r_fwd_row  <= r_to_row;
            r_fwd_data <= w_wdata;
        end
    end

    // Result word.
    assign o_res_vld       = r_ctl.vld;
    assign o_res.accepted  = r_ctl.acc;
    assign o_res.carve     = w_carve;
    assign o_res.from_row  = mrwc_pkg::POS_W'(r_from_row);
    assign o_res.from_col  = mrwc_pkg::POS_W'(r_from_col);
    assign o_res.to_row    = mrwc_pkg::POS_W'(r_to_row);
    assign o_res.to_col    = mrwc_pkg::POS_W'(r_to_col);
    assign o_res.done_res  = o_done_now;

endmodule

/* rtl/core/mrwc_outq.sv */
module mrwc_outq (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    input  mrwc_pkg::t_result                          i_data,
    input  logic                                       i_rdy,
    output logic                                       o_vld,
    output mrwc_pkg::t_result                          o_data,
    output logic [$clog2(mrwc_pkg::OUTQ_DEPTH+1)-1:0]  o_count
);

    localparam int DEPTH = mrwc_pkg::OUTQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH+1);

    mrwc_pkg::t_result r_slot [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              w_pop;

    assign w_pop = o_vld && i_rdy;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_vld   = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* rtl/core/maze_random_walk_carver.sv */
// A taken word passes the walk input register, the mark stage register and the queue.
// One input word per cycle while there is room; the walk position and visited count
// settle within the cycle after an item, and the visited row is read a stage ahead.
// A four-word result queue keeps taking input while results wait downstream.
// Reset (synchronous, active low) clears the walk, the visited row flags, the count
// and the queue, and loads 15 rows by 20 columns; no clearing pass follows.
module maze_random_walk_carver #(
    parameter int MAX_ROWS = mrwc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mrwc_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: seed_row[4:0], seed_col[9:5], direction[11:10], zero[15:12]
    input  logic [mrwc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: opcode[0]
    input  logic                           i_s_tuser,
    // Result stream.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: accepted[0], carve[1], from_row[6:2], from_col[11:7], to_row[16:12],
    // to_col[21:17], done_res[22], zero[23]
    output logic [mrwc_pkg::M_TDATA_W-1:0] o_m_tdata,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrwc_pkg::CFG_AW-1:0]    paddr,
    input  logic [mrwc_pkg::CFG_DW-1:0]    pwdata,
    output logic [mrwc_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DR    = $clog2(MAX_ROWS+1);
    localparam int DC    = $clog2(MAX_COLS+1);
    localparam int CNT_W = $clog2(MAX_ROWS*MAX_COLS+1);
    localparam int GW    = mrwc_pkg::GRID_W;
    localparam int DW    = mrwc_pkg::DIM_W;
    localparam int QCW   = $clog2(mrwc_pkg::OUTQ_DEPTH+1);
    localparam int IFW   = QCW + 1;

    logic [GW-1:0]        r_grid_rows;
    logic [GW-1:0]        r_grid_cols;
    logic                 w_cfg_wr;
    logic [DW-1:0]        w_rows_clip;
    logic [DW-1:0]        w_cols_clip;
    logic [DR-1:0]        w_rows_eff;
    logic [DC-1:0]        w_cols_eff;
    logic [CNT_W-1:0]     w_total;

    logic                 w_in_acc;
    logic                 w_active;
    logic                 w_done_now;
    mrwc_pkg::t_stage_ctl w_ctl;
    logic [RW-1:0]        w_from_row;
    logic [CW-1:0]        w_from_col;
    logic [RW-1:0]        w_to_row;
    logic [CW-1:0]        w_to_col;
    logic                 w_res_vld;
    mrwc_pkg::t_result    w_res;
    mrwc_pkg::t_result    w_q_data;
    logic [QCW-1:0]       w_q_count;
    logic [IFW-1:0]       w_inflight;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= mrwc_pkg::ROWS_RST;
            r_grid_cols <= mrwc_pkg::COLS_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[mrwc_pkg::CFG_AW-1])
                mrwc_pkg::REG_ROWS: r_grid_rows <= pwdata[GW-1:0];
                mrwc_pkg::REG_COLS: r_grid_cols <= pwdata[GW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[mrwc_pkg::CFG_AW-1])
            mrwc_pkg::REG_ROWS: prdata = {{(mrwc_pkg::CFG_DW-GW){1'b0}}, r_grid_rows};
            mrwc_pkg::REG_COLS: prdata = {{(mrwc_pkg::CFG_DW-GW){1'b0}}, r_grid_cols};
        endcase
    end

    // Grid in use: zero acts as one, anything above capacity acts as capacity.
    always_comb begin
        priority if (r_grid_rows == '0) begin
            w_rows_clip = DW'(1);
        end else if (DW'(r_grid_rows) > DW'(MAX_ROWS)) begin
            w_rows_clip = DW'(MAX_ROWS);
        end else begin
            w_rows_clip = DW'(r_grid_rows);
        end
        priority if (r_grid_cols == '0) begin
            w_cols_clip = DW'(1);
        end else if (DW'(r_grid_cols) > DW'(MAX_COLS)) begin
            w_cols_clip = DW'(MAX_COLS);
        end else begin
            w_cols_clip = DW'(r_grid_cols);
        end
    end

    assign w_rows_eff = DR'(w_rows_clip);
    assign w_cols_eff = DC'(w_cols_clip);
    assign w_total    = CNT_W'(w_rows_eff) * CNT_W'(w_cols_eff);

    // Take a word only when the queue has room for everything in flight.
    assign w_inflight = IFW'(w_q_count) + IFW'(w_ctl.vld) + IFW'(w_res_vld);
    assign o_s_tready = (w_inflight < IFW'(mrwc_pkg::OUTQ_DEPTH));
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    mrwc_walk #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_vld   (w_in_acc),
        .i_opcode   (mrwc_pkg::t_opcode'(i_s_tuser)),
        .i_seed_row (i_s_tdata[4:0]),
        .i_seed_col (i_s_tdata[9:5]),
        .i_dir      (mrwc_pkg::t_dir'(i_s_tdata[11:10])),
        .i_rows_eff (w_rows_eff),
        .i_cols_eff (w_cols_eff),
        .i_done_now (w_done_now),
        .o_active   (w_active),
        .o_ctl      (w_ctl),
        .o_from_row (w_from_row),
        .o_from_col (w_from_col),
        .o_to_row   (w_to_row),
        .o_to_col   (w_to_col)
    );

    mrwc_mark #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_mark (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_from_row (w_from_row),
        .i_from_col (w_from_col),
        .i_to_row   (w_to_row),
        .i_to_col   (w_to_col),
        .i_active   (w_active),
        .i_total    (w_total),
        .o_done_now (w_done_now),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res)
    );

    mrwc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_vld),
        .i_data  (w_res),
        .i_rdy   (i_m_tready),
        .o_vld   (o_m_tvalid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign o_m_tdata = {{mrwc_pkg::RES_PAD{1'b0}}, w_q_data};

endmodule

/* rtl/core/mrwc_checker.sv */
module mrwc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [mrwc_pkg::M_TDATA_W-1:0] o_m_tdata
);

    mrwc_pkg::t_result w_res;

    assign w_res = o_m_tdata[$bits(mrwc_pkg::t_result)-1:0];

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // A wall is only removed by an item that moved the walk.
    a_carve_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_res.carve |-> w_res.accepted)
        else $error("carve reported on a rejected item");

    // A rejected item leaves the position where it was.
    a_reject_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !w_res.accepted |->
            (w_res.from_row == w_res.to_row) && (w_res.from_col == w_res.to_col))
        else $error("rejected item moved the walk");

    // Every taken word has a result on the output once it has passed the walk and marking stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> ##2 o_m_tvalid)
        else $error("result missing three cycles after input");

endmodule

bind maze_random_walk_carver mrwc_checker u_mrwc_checker (.*);
